FILE: src/mwis_pkg.sv
// ----------------------------------------------------------------------------
// mwis_pkg
// Shared widths, types and the controller state encoding for the
// max-weight increasing subsequence block.
// ----------------------------------------------------------------------------
package mwis_pkg;

    localparam int KEY_BITS    = 12;
    localparam int WEIGHT_BITS = 32;
    localparam int VALUE_BITS  = 48;
    localparam int KEY_COUNT   = 1 << KEY_BITS;
    localparam int NODE_COUNT  = 2 * KEY_COUNT;
    localparam int NODE_BITS   = $clog2(NODE_COUNT);
    localparam int LEVELS      = KEY_BITS;
    localparam int LEVEL_BITS  = $clog2(LEVELS + 1);

    typedef logic [KEY_BITS-1:0]    t_key;
    typedef logic [WEIGHT_BITS-1:0] t_weight;
    typedef logic [VALUE_BITS-1:0]  t_value;
    typedef logic [NODE_BITS-1:0]   t_node_addr;
    typedef logic [LEVEL_BITS-1:0]  t_level;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUERY,
        ST_DRAIN,
        ST_SUM,
        ST_UPDATE,
        ST_WB,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       we;
        t_node_addr waddr;
        t_value     wdata;
        logic       re;
        t_node_addr raddr;
    } t_ram_req;

    typedef struct packed {
        logic   valid;
        t_value chain;
        t_value best;
    } t_res;

endpackage

FILE: src/mwis_ifs.sv
// ----------------------------------------------------------------------------
// mwis_ifs
// Valid/ready channels for requests (key, weight) and results
// (chain value, running best).
// ----------------------------------------------------------------------------
interface mwis_in_if;
    import mwis_pkg::*;

    logic    valid;
    logic    ready;
    t_key    key;
    t_weight weight;

    modport source (output valid, output key, output weight, input ready);
    modport sink   (input valid, input key, input weight, output ready);
endinterface

interface mwis_out_if;
    import mwis_pkg::*;

    logic   valid;
    logic   ready;
    t_value chain_value;
    t_value best_so_far;

    modport source (output valid, output chain_value, output best_so_far, input ready);
    modport sink   (input valid, input chain_value, input best_so_far, output ready);
endinterface

FILE: src/mwis_ram.sv
// ----------------------------------------------------------------------------
// mwis_ram
// Tree node store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mwis_ram (
    input  logic                i_clk,
    input  mwis_pkg::t_ram_req  i_req,
    output mwis_pkg::t_value    o_rdata
);
    import mwis_pkg::*;

    t_value r_mem [NODE_COUNT];
    t_value r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/mwis_ctrl.sv
// ----------------------------------------------------------------------------
// mwis_ctrl
// Sequencer: clears the tree after reset, walks the prefix query one level
// a cycle, forms the saturated chain value, then raises every node on the
// key's path by read-modify-write.
// ----------------------------------------------------------------------------
module mwis_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mwis_in_if.sink             i_req,
    output mwis_pkg::t_ram_req  o_ram,
    input  mwis_pkg::t_value    i_rdata,
    output mwis_pkg::t_res      o_res,
    input  logic                i_res_ready
);
    import mwis_pkg::*;

    t_state     r_state, n_state;
    t_level     r_level, n_level;
    t_node_addr r_clr_addr, n_clr_addr;
    logic       r_rd_pend, n_rd_pend;
    t_node_addr r_wb_addr, n_wb_addr;
    t_key       r_key, n_key;
    t_weight    r_weight, n_weight;
    t_value     r_acc, n_acc;
    t_value     r_chain, n_chain;
    t_value     r_best, n_best;

    logic                 last_level;
    t_node_addr           path_node;
    logic [VALUE_BITS:0]  sum;
    t_value               chain_sat;
    t_value               raised;

    assign last_level = (r_level == t_level'(LEVELS - 1));
    // node on the key's path at the current level
    assign path_node  = t_node_addr'({1'b1, r_key} >> r_level);
    assign sum        = {1'b0, r_acc} + (VALUE_BITS+1)'(r_weight);
    assign chain_sat  = sum[VALUE_BITS] ? {VALUE_BITS{1'b1}} : sum[VALUE_BITS-1:0];
    assign raised     = (i_rdata > r_chain) ? i_rdata : r_chain;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr_addr == t_node_addr'(NODE_COUNT - 1)) n_state = ST_IDLE;
            ST_IDLE:   if (i_req.valid) n_state = ST_QUERY;
            ST_QUERY:  if (last_level) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_SUM;
            ST_SUM:    n_state = ST_UPDATE;
            ST_UPDATE: if (last_level) n_state = ST_WB;
            ST_WB:     n_state = ST_DONE;
            ST_DONE:   if (i_res_ready) n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_level    = r_level;
        n_clr_addr = r_clr_addr;
        n_rd_pend  = 1'b0;
        n_wb_addr  = r_wb_addr;
        n_key      = r_key;
        n_weight   = r_weight;
        n_acc      = r_acc;
        n_chain    = r_chain;
        n_best     = r_best;
        o_ram      = '0;
        i_req.ready = 1'b0;
        o_res.valid = 1'b0;
        o_res.chain = r_chain;
        o_res.best  = r_best;

        // returning query read folds into the prefix maximum
        if (r_rd_pend && (r_state == ST_QUERY || r_state == ST_DRAIN)) begin
            if (i_rdata > r_acc) n_acc = i_rdata;
        end
        // returning path read is raised and written back
        if (r_rd_pend && (r_state == ST_UPDATE || r_state == ST_WB)) begin
            o_ram.we    = 1'b1;
            o_ram.waddr = r_wb_addr;
            o_ram.wdata = raised;
        end

        unique case (r_state)
            ST_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_clr_addr;
                o_ram.wdata = '0;
                n_clr_addr  = r_clr_addr + 1'b1;
            end
            ST_IDLE: begin
                i_req.ready = 1'b1;
                n_key       = i_req.key;
                n_weight    = i_req.weight;
                n_acc       = '0;
                n_level     = '0;
            end
            ST_QUERY: begin
                // left sibling of the path node covers keys below the key
                if (r_key[r_level]) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = path_node - 1'b1;
                    n_rd_pend   = 1'b1;
                end
                n_level = last_level ? '0 : r_level + 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_SUM: begin
                n_chain = chain_sat;
                n_best  = (chain_sat > r_best) ? chain_sat : r_best;
                n_level = '0;
            end
            ST_UPDATE: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = path_node;
                n_rd_pend   = 1'b1;
                n_wb_addr   = path_node;
                n_level     = last_level ? '0 : r_level + 1'b1;
            end
            ST_WB: begin
            end
            ST_DONE: begin
                o_res.valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_level    <= '0;
            r_clr_addr <= '0;
            r_rd_pend  <= 1'b0;
            r_best     <= '0;
        end else begin
            r_state    <= n_state;
            r_level    <= n_level;
            r_clr_addr <= n_clr_addr;
            r_rd_pend  <= n_rd_pend;
            r_best     <= n_best;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_addr <= n_wb_addr;
        r_key     <= n_key;
        r_weight  <= n_weight;
        r_acc     <= n_acc;
        r_chain   <= n_chain;
    end

endmodule

FILE: src/max_weight_increasing_subsequence_top.sv
// ----------------------------------------------------------------------------
// max_weight_increasing_subsequence_top
// Streaming max-weight strictly increasing chain over a max tree by key.
// ----------------------------------------------------------------------------
// After reset the block sweeps zeros through all 8192 tree nodes, one node a
// cycle, and takes no request until the sweep is done. Before the next request
// can be taken, each request goes through 12 prefix-query steps, one per tree
// level below the root, a drain step, a sum step, 12 read-modify-write steps
// up the key's path and a final write-back, all through the single read port
// and single write port of the tree memory, plus the hand-off to the output
// register. The result register lets a finished result wait while the next
// request is already being worked on; chain values saturate at all ones.
module max_weight_increasing_subsequence_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mwis_in_if.sink   i_req,
    mwis_out_if.source o_res
);
    import mwis_pkg::*;

    t_ram_req ram_req;
    t_value   ram_rdata;
    t_res     res;
    logic     res_ready;

    logic   r_out_valid;
    t_value r_out_chain;
    t_value r_out_best;

    mwis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    mwis_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res.valid) begin
            r_out_chain <= res.chain;
            r_out_best  <= res.best;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.chain_value = r_out_chain;
    assign o_res.best_so_far = r_out_best;

    // read and write never target the same node in one cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
        else $error("tree read and write to same node");

    // no tree write is in flight while a new request is taken
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !ram_req.we)
        else $error("tree write while taking request");

    // running best never falls below the chain value it reports with
    a_best_covers_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.best_so_far >= o_res.chain_value))
        else $error("best below chain value");

endmodule

FILE: tb/sv/max_weight_increasing_subsequence_top_tb.sv
// ----------------------------------------------------------------------------
// max_weight_increasing_subsequence_top_tb
// Drives keyed, weighted requests through the valid/ready request channel and
// checks each chain value and running best against a flat per-key model of
// the best chain ending at every key. The sender works in bursts and the
// receiver stalls on a rotating pattern, with long holds and drain pauses.
// ----------------------------------------------------------------------------
module max_weight_increasing_subsequence_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mwis_pkg::*;

    typedef struct {
        t_key    key;
        t_weight weight;
        bit      wait_idle;
    } t_request;

    typedef struct packed {
        t_value chain;
        t_value best;
    } t_chain_result;

    logic i_clk;
    logic i_rst_n;

    mwis_in_if  req_if ();
    mwis_out_if res_if ();

    max_weight_increasing_subsequence_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_request      request_q [$];
    t_chain_result chain_result_q [$];

    // best chain ending at each key, and the best chain overall
    t_value chain_at_key [KEY_COUNT];
    t_value top_chain;

    int mismatch_count = 0;
    int results_owed;
    int results_checked;

    int burst_left;
    int gap_left;
    int hold_left;
    int holds_done;
    int pattern_left;
    logic [15:0] stall_pattern;

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.key    = '0;
        req_if.weight = '0;
        res_if.ready  = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50) begin
            $display("[%0t] ERROR: %s", $time, msg);
        end
    endtask

    function automatic t_chain_result extend_chain(input t_key k, input t_weight w);
        t_chain_result r;
        t_value prefix_top;
        logic [VALUE_BITS:0] sum;
        prefix_top = '0;
        for (int i = 0; i < int'(k); i++) begin
            if (chain_at_key[i] > prefix_top) prefix_top = chain_at_key[i];
        end
        sum = {1'b0, prefix_top} + {{(VALUE_BITS + 1 - WEIGHT_BITS){1'b0}}, w};
        // clamp at all ones on overflow
        r.chain = sum[VALUE_BITS] ? '1 : sum[VALUE_BITS-1:0];
        if (r.chain > chain_at_key[k]) chain_at_key[k] = r.chain;
        if (r.chain > top_chain) top_chain = r.chain;
        r.best = top_chain;
        return r;
    endfunction

    function automatic t_weight rand_weight();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return '0;
            2: return t_weight'($urandom_range(0, 255));
            default: return t_weight'($urandom);
        endcase
    endfunction

    function automatic void add_request(input t_key k, input t_weight w, input bit wait_idle);
        t_request r;
        r.key       = k;
        r.weight    = w;
        r.wait_idle = wait_idle;
        request_q.push_back(r);
    endfunction

    // stimulus
    initial begin
        int k;
        int run_len;
        int total;
        t_key rep_key;

        add_request(12'd0, 32'd0, 1'b0);
        add_request(12'd0, '1, 1'b0);
        add_request(12'd0, 32'd5, 1'b0);
        add_request(12'hFFF, '1, 1'b0);
        add_request(12'hFFF, 32'd0, 1'b0);
        add_request(12'd1, 32'd1, 1'b0);
        add_request(12'h555, 32'h5555_5555, 1'b0);
        add_request(12'hAAA, 32'hAAAA_AAAA, 1'b0);
        for (int i = 1; i <= 8; i++) begin
            add_request(t_key'(i * 256), '1, 1'b0);
        end
        add_request(12'h7FF, 32'h8000_0000, 1'b1);
        add_request(12'h800, 32'h7FFF_FFFF, 1'b0);

        total = request_q.size() + 800;
        while (request_q.size() < total) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    // increasing run, the shape that builds long chains
                    k = $urandom_range(0, 2047);
                    run_len = $urandom_range(4, 40);
                    for (int j = 0; j < run_len && k < KEY_COUNT; j++) begin
                        add_request(t_key'(k), rand_weight(), request_q.size() % 250 == 0);
                        k += $urandom_range(1, 120);
                    end
                end
                6, 7: begin
                    for (int j = 0; j < 8; j++) begin
                        add_request(t_key'($urandom), t_weight'($urandom), 1'b0);
                    end
                end
                8: begin
                    rep_key = t_key'($urandom);
                    run_len = $urandom_range(2, 5);
                    for (int j = 0; j < run_len; j++) begin
                        add_request(rep_key, rand_weight(), 1'b0);
                    end
                end
                default: begin
                    k = $urandom_range(KEY_COUNT / 2, KEY_COUNT - 1);
                    run_len = $urandom_range(3, 12);
                    for (int j = 0; j < run_len && k >= 0; j++) begin
                        add_request(t_key'(k), rand_weight(), 1'b0);
                        k -= $urandom_range(1, 200);
                    end
                end
            endcase
        end

        @(posedge i_clk);
        while (!i_rst_n || request_q.size() != 0 || req_if.valid || results_owed != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
        if (chain_result_q.size() != 0) begin
            report_error($sformatf("%0d results never arrived", chain_result_q.size()));
        end
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // request driver: bursts of requests with random gaps
    always @(posedge i_clk) begin
        bit offer;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid) begin
                request_q.delete(0);
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    case ($urandom_range(0, 3))
                        0: gap_left = 0;
                        1: gap_left = $urandom_range(1, 5);
                        2: gap_left = $urandom_range(6, 30);
                        default: gap_left = $urandom_range(31, 70);
                    endcase
                end
            end
            // a draining request waits until nothing is in flight
            offer = gap_left == 0 && request_q.size() > 0 &&
                    (!request_q[0].wait_idle || (!req_if.valid && results_owed == 0));
            if (gap_left > 0) gap_left--;
            if (offer) begin
                req_if.valid  <= 1'b1;
                req_if.key    <= request_q[0].key;
                req_if.weight <= request_q[0].weight;
            end else begin
                req_if.valid  <= 1'b0;
                req_if.key    <= t_key'($urandom);
                req_if.weight <= t_weight'($urandom);
            end
        end
    end

    // result receiver: rotating stall pattern plus two long holds
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_left     = 0;
            holds_done    = 0;
            pattern_left  = 0;
            stall_pattern = '1;
        end else begin
            if (hold_left == 0 && holds_done < 2 &&
                results_checked >= (holds_done == 0 ? 120 : 520)) begin
                hold_left = 400;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern_left = $urandom_range(16, 400);
                    if ($urandom_range(0, 3) == 0) begin
                        stall_pattern = '1;
                    end else begin
                        stall_pattern = 16'($urandom) | (16'h1 << $urandom_range(0, 15));
                    end
                end
                pattern_left--;
                res_if.ready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
        end
    end

    // monitor: predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin
        t_chain_result want;
        int delta;
        if (!i_rst_n) begin
            results_owed    <= 0;
            results_checked <= 0;
            for (int i = 0; i < KEY_COUNT; i++) chain_at_key[i] = '0;
            top_chain = '0;
        end else begin
            delta = 0;
            if (req_if.valid && req_if.ready) begin
                chain_result_q.push_back(extend_chain(req_if.key, req_if.weight));
                delta++;
            end
            if (res_if.valid && res_if.ready) begin
                results_checked <= results_checked + 1;
                if (chain_result_q.size() == 0) begin
                    report_error("result with no request outstanding");
                end else begin
                    want = chain_result_q.pop_front();
                    delta--;
                    if (res_if.chain_value !== want.chain) begin
                        report_error($sformatf("result %0d chain_value %0h, expected %0h",
                                               results_checked, res_if.chain_value, want.chain));
                    end
                    if (res_if.best_so_far !== want.best) begin
                        report_error($sformatf("result %0d best_so_far %0h, expected %0h",
                                               results_checked, res_if.best_so_far, want.best));
                    end
                end
            end
            results_owed <= results_owed + delta;
        end
    end

endmodule
